// ----- rtl/pss_pkg.sv -----
package pss_pkg;

  localparam int CAPACITY = 64;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int POS_W    = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

  // Outcome of one command as seen by the output stage
  typedef struct packed {
    logic             rd_ok;
    logic [POS_W-1:0] length_next;
    status_t          status;
  } ctrl_res_t;

endpackage

// ----- rtl/pss_cell.sv -----
module pss_cell (
  input  logic                             clk,
  input  logic [pss_pkg::IDX_W-1:0]        idx,
  input  pss_pkg::cell_cmd_t               cmd,
  input  logic [pss_pkg::VALUE_W-1:0]      left,
  input  logic [pss_pkg::VALUE_W-1:0]      right,
  output logic [pss_pkg::VALUE_W-1:0]      data,
  output logic [pss_pkg::VALUE_W-1:0]      rd
);

  logic [pss_pkg::POS_W-1:0]   my_pos;
  logic [pss_pkg::VALUE_W-1:0] data_next;

  assign my_pos = {1'b0, idx};

  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (my_pos > cmd.pos) begin
        data_next = left;
      end else if (my_pos == cmd.pos) begin
        data_next = cmd.value;
      end
    end else if (cmd.rem && my_pos >= cmd.pos) begin
      data_next = right;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Drive own word onto the read bus only when addressed
  assign rd = (my_pos == cmd.pos) ? data : '0;

endmodule

// ----- rtl/pss_ctrl.sv -----
module pss_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [1:0]                  operation,
  input  logic [pss_pkg::POS_W-1:0]   position,
  input  logic [pss_pkg::VALUE_W-1:0] value_in,
  output pss_pkg::cell_cmd_t          cmd,
  output pss_pkg::ctrl_res_t          res
);

  localparam logic [pss_pkg::POS_W-1:0] CapLen = pss_pkg::POS_W'(pss_pkg::CAPACITY);

  logic [pss_pkg::POS_W-1:0] count;
  logic [pss_pkg::POS_W-1:0] count_next;
  pss_pkg::op_t              op;
  pss_pkg::status_t          st;
  logic                      ins_ok;
  logic                      rem_ok;
  logic                      rd_ok;

  assign op = pss_pkg::op_t'(operation);

  always_comb begin
    st     = pss_pkg::ST_OK;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    rd_ok  = 1'b0;
    count_next = count;
    unique case (op)
      pss_pkg::OP_INSERT: begin
        if (count >= CapLen) begin
          st = pss_pkg::ST_FULL;
        end else if (position > count) begin
          st = pss_pkg::ST_RANGE;
        end else begin
          ins_ok     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      pss_pkg::OP_REMOVE, pss_pkg::OP_READ: begin
        if (count == '0) begin
          st = pss_pkg::ST_EMPTY;
        end else if (position >= count) begin
          st = pss_pkg::ST_RANGE;
        end else begin
          rd_ok = 1'b1;
          if (op == pss_pkg::OP_REMOVE) begin
            rem_ok     = 1'b1;
            count_next = count - 1'b1;
          end
        end
      end
      pss_pkg::OP_CLEAR: begin
        count_next = '0;
      end
      default: begin
        st = pss_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  assign cmd.ins   = accept & ins_ok;
  assign cmd.rem   = accept & rem_ok;
  assign cmd.pos   = position;
  assign cmd.value = value_in;

  assign res.rd_ok       = rd_ok;
  assign res.length_next = count_next;
  assign res.status      = st;

endmodule

// ----- rtl/positional_sequence_store_unit.sv -----
// Latency: a command taken at one edge has its result on the ports for the
// following cycle, marked by done.
// Throughput: one command per cycle; every cell shifts or loads in parallel,
// so busy never rises.
// Reset: synchronous rst clears the stored count and done; length and entry
// words keep their contents and become invalid. Results cannot be stalled.
module positional_sequence_store_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         operation,
  input  logic [pss_pkg::POS_W-1:0]          position,
  input  logic signed [pss_pkg::VALUE_W-1:0] value_in,
  output logic                               done,
  output logic signed [pss_pkg::VALUE_W-1:0] value_out,
  output logic [pss_pkg::POS_W-1:0]          length,
  output logic [1:0]                         status
);

  localparam int N = pss_pkg::CAPACITY;

  pss_pkg::cell_cmd_t          cmd;
  pss_pkg::ctrl_res_t          res;
  logic                        accept;
  logic [pss_pkg::VALUE_W-1:0] cell_data [N];
  logic [pss_pkg::VALUE_W-1:0] cell_rd   [N];
  logic [pss_pkg::VALUE_W-1:0] rd_word;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .position  (position),
    .value_in  (value_in),
    .cmd       (cmd),
    .res       (res)
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [pss_pkg::VALUE_W-1:0] left_w;
    logic [pss_pkg::VALUE_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_data[i];
    end else begin : g_mid
      assign left_w = cell_data[i-1];
    end
    if (i == N-1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_inner
      assign right_w = cell_data[i+1];
    end
    pss_cell u_cell (
      .clk   (clk),
      .idx   (pss_pkg::IDX_W'(i)),
      .cmd   (cmd),
      .left  (left_w),
      .right (right_w),
      .data  (cell_data[i]),
      .rd    (cell_rd[i])
    );
  end

  // At most one cell drives its word, so an OR collects the read beat
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < N; k++) begin
      rd_word = rd_word | cell_rd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_out <= res.rd_ok ? rd_word : '0;
      length    <= res.length_next;
      status    <= res.status;
    end
  end

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> done) else $error("result beat missing");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> length <= pss_pkg::POS_W'(pss_pkg::CAPACITY))
    else $error("length beyond capacity");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == pss_pkg::ST_FULL) |->
      length == pss_pkg::POS_W'(pss_pkg::CAPACITY))
    else $error("full flagged below capacity");

  a_empty_len: assert property (@(posedge clk) disable iff (rst)
    (done && status == pss_pkg::ST_EMPTY) |-> length == '0)
    else $error("empty flagged with entries held");

  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != pss_pkg::ST_OK) |-> value_out == '0)
    else $error("flagged beat carries a value");

endmodule
